// ===== rtl/led_effect_sequencer_top_defines.svh =====
// Assertion macros for the LED effect sequencer.
// Used by led_effect_sequencer_top; expects clk and rst_n in scope.
`ifndef LED_EFFECT_SEQUENCER_TOP_DEFINES_SVH
`define LED_EFFECT_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/les_pkg.sv =====
// Types and codes of the LED effect sequencer.
// No dependencies; used by the interfaces and the top level.
package les_pkg;

    typedef logic [7:0] level_t;
    typedef logic [2:0] prog_t;
    typedef logic [1:0] phase_t;
    typedef logic [2:0] chan_t;
    typedef logic [9:0] duty_t;
    typedef logic [2:0] count_t;
    typedef logic [2:0] cfg_addr_t;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Channel programs
    localparam prog_t PRG_OFF     = 3'd0;
    localparam prog_t PRG_NOMINAL = 3'd1;
    localparam prog_t PRG_MAX     = 3'd2;
    localparam prog_t PRG_BRAKE   = 3'd3;
    localparam prog_t PRG_FADE    = 3'd4;
    localparam prog_t PRG_FLASH   = 3'd5;

    // Program phases
    localparam phase_t PH_START  = 2'd0;
    localparam phase_t PH_ACTIVE = 2'd1;
    localparam phase_t PH_FALL   = 2'd2;

    // Configuration register indexes
    localparam cfg_addr_t CFG_MAX_LEVEL      = 3'd0;
    localparam cfg_addr_t CFG_MIN_LEVEL      = 3'd1;
    localparam cfg_addr_t CFG_BRAKE_LEVEL    = 3'd2;
    localparam cfg_addr_t CFG_BACK_NOMINAL   = 3'd3;
    localparam cfg_addr_t CFG_FRONT_NOMINAL  = 3'd4;
    localparam cfg_addr_t CFG_STEP_SIZE      = 3'd5;
    localparam cfg_addr_t CFG_DONE_THRESHOLD = 3'd6;

    // Number of duty fields in a result
    localparam int DUTY_FIELDS = 6;

    // One channel entry of the program memory
    typedef struct packed {
        prog_t  prog;
        level_t level;
        level_t speed;
        phase_t phase;
    } chan_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/les_intf.sv =====
// Handshake channels of the LED effect sequencer: command, result, config.
// Depends on les_pkg for payload types.
interface les_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    les_pkg::chan_t     channel;
    les_pkg::prog_t     program_req;
    les_pkg::level_t    level;
    les_pkg::phase_t    phase;
    les_pkg::level_t    speed;

    modport source (output valid, operation, channel, program_req, level, phase, speed,
                    input ready);
    modport sink   (input valid, operation, channel, program_req, level, phase, speed,
                    output ready);
endinterface

interface les_out_if;
    logic               valid;
    logic               ready;
    les_pkg::duty_t     duty_ch0;
    les_pkg::duty_t     duty_ch1;
    les_pkg::duty_t     duty_ch2;
    les_pkg::duty_t     duty_ch3;
    les_pkg::duty_t     duty_ch4;
    les_pkg::duty_t     duty_ch5;
    les_pkg::count_t    done_count;
    logic               all_done;

    modport source (output valid, duty_ch0, duty_ch1, duty_ch2, duty_ch3, duty_ch4,
                    duty_ch5, done_count, all_done, input ready);
    modport sink   (input valid, duty_ch0, duty_ch1, duty_ch2, duty_ch3, duty_ch4,
                    duty_ch5, done_count, all_done, output ready);
endinterface

interface les_cfg_if;
    logic                  valid;
    logic                  ready;
    les_pkg::cfg_addr_t    addr;
    les_pkg::level_t       data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/led_effect_sequencer_top.sv =====
// LED effect sequencer top level: channel program memory, tick sequencer, result register.
// Depends on les_pkg, les_intf.sv and led_effect_sequencer_top_defines.svh.
`include "led_effect_sequencer_top_defines.svh"

// A load transaction writes one channel entry and presents its result on the cycle after
// acceptance. A tick transaction walks the channels one per cycle through the single read
// port of the channel memory: each entry is read, updated and written back in the next
// cycle; the result is registered from the FINISH state after the last channel. One
// transaction is in work at a time; a new command is taken once the block
// is idle and the result register is empty or being emptied. Config writes are always
// ready and take effect on the next cycle. Channel state clears at reset with no sweep.
module led_effect_sequencer_top #(
    parameter int NUM_CHANNELS = 6,
    parameter int DUTY_SCALE   = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    les_in_if.sink     cmd,
    les_out_if.source  res,
    les_cfg_if.sink    cfg
);
    import les_pkg::*;

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W     = $clog2(NUM_CHANNELS + 1);
    localparam int NUM_SHOWN = (NUM_CHANNELS < DUTY_FIELDS) ? NUM_CHANNELS : DUTY_FIELDS;
    localparam int PROD_RAW  = 8 + $clog2(DUTY_SCALE + 1);
    localparam int PROD_W    = (PROD_RAW > 10) ? PROD_RAW : 10;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    // Configuration registers
    level_t max_level_reg;
    level_t min_level_reg;
    level_t brake_level_reg;
    level_t back_nominal_reg;
    level_t front_nominal_reg;
    level_t step_size_reg;
    count_t done_threshold_reg;

    // Control
    state_t            state_reg, state_next;
    logic [CH_W-1:0]   rd_idx_reg, rd_idx_next;
    logic              s1_vld_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    logic [CNT_W-1:0]  done_acc_reg;
    logic [CNT_W-1:0]  done_total;
    count_t            done_sat;

    // Channel memories and their reset tracking
    chan_entry_t       main_mem [NUM_CHANNELS];
    level_t            cnt_mem  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] main_vld_reg;
    logic [NUM_CHANNELS-1:0] cnt_vld_reg;
    chan_entry_t       main_rd_reg;
    level_t            cnt_rd_reg;
    logic              main_rd_vld_reg;
    logic              cnt_rd_vld_reg;

    logic              mem_we;
    logic [CH_W-1:0]   mem_waddr;
    chan_entry_t       mem_wdata;

    // Channel update
    chan_entry_t       cur;
    chan_entry_t       nxt;
    level_t            cnt_cur;
    level_t            cnt_new;
    level_t            cnt_inc;
    level_t            cnt_step;
    logic              stepped;
    logic [8:0]        rise_sum;
    logic              fall_neg;
    level_t            fall_val;
    level_t            nom_lvl;
    level_t            floor_lvl;
    logic              fin;

    // Result
    logic              res_vld_reg;
    count_t            done_cnt_reg;
    logic              all_done_reg;
    level_t            lvl_reg [NUM_SHOWN];
    duty_t             duty_w  [DUTY_FIELDS];

    logic              cmd_acc;
    logic              load_hit;

    assign cmd.ready = (state_reg == ST_IDLE) && (!res_vld_reg || res.ready);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign load_hit  = cmd_acc && (cmd.operation == OP_LOAD)
                       && (5'(cmd.channel) < 5'(NUM_CHANNELS));

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg      <= 8'd255;
            min_level_reg      <= 8'd0;
            brake_level_reg    <= 8'd200;
            back_nominal_reg   <= 8'd64;
            front_nominal_reg  <= 8'd128;
            step_size_reg      <= 8'd1;
            done_threshold_reg <= 3'd5;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                CFG_MAX_LEVEL:      max_level_reg      <= cfg.data;
                CFG_MIN_LEVEL:      min_level_reg      <= cfg.data;
                CFG_BRAKE_LEVEL:    brake_level_reg    <= cfg.data;
                CFG_BACK_NOMINAL:   back_nominal_reg   <= cfg.data;
                CFG_FRONT_NOMINAL:  front_nominal_reg  <= cfg.data;
                CFG_STEP_SIZE:      step_size_reg      <= cfg.data;
                CFG_DONE_THRESHOLD: done_threshold_reg <= cfg.data[2:0];
                default:            ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && (cmd.operation == OP_TICK))
                begin
                    state_next  = ST_RUN;
                    rd_idx_next = '0;
                end
            end
            ST_RUN:
            begin
                if (rd_idx_reg == LAST_CH)
                    state_next = ST_FINISH;
                else
                    rd_idx_next = rd_idx_reg + 1'b1;
            end
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_idx_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            s1_ch_reg    <= '0;
            done_acc_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            // the read issued in RUN is updated and written back in the next cycle
            s1_vld_reg <= (state_reg == ST_RUN);
            s1_ch_reg  <= rd_idx_reg;
            if (cmd_acc)
                done_acc_reg <= '0;
            else if (s1_vld_reg)
                done_acc_reg <= done_total;
        end
    end

    assign done_total = done_acc_reg + CNT_W'(fin);
    assign done_sat   = (int'(done_total) > 7) ? 3'd7 : 3'(done_total);

    // ---------------- channel memories ----------------
    assign mem_we    = s1_vld_reg || load_hit;
    assign mem_waddr = s1_vld_reg ? s1_ch_reg : CH_W'(cmd.channel);
    assign mem_wdata = s1_vld_reg ? nxt
                                  : chan_entry_t'{prog: cmd.program_req, level: cmd.level,
                                                  speed: cmd.speed, phase: cmd.phase};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            main_mem[mem_waddr] <= mem_wdata;
        if (s1_vld_reg)
            cnt_mem[s1_ch_reg] <= cnt_new;
        main_rd_reg     <= main_mem[rd_idx_reg];
        cnt_rd_reg      <= cnt_mem[rd_idx_reg];
        main_rd_vld_reg <= main_vld_reg[rd_idx_reg];
        cnt_rd_vld_reg  <= cnt_vld_reg[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= '0;
            cnt_vld_reg  <= '0;
        end
        else
        begin
            if (mem_we)
                main_vld_reg[mem_waddr] <= 1'b1;
            if (s1_vld_reg)
                cnt_vld_reg[s1_ch_reg] <= 1'b1;
        end
    end

    // ---------------- channel update ----------------
    assign cur     = main_rd_vld_reg ? main_rd_reg : '0;
    assign cnt_cur = cnt_rd_vld_reg ? cnt_rd_reg : '0;

    always_comb
    begin
        if (int'(s1_ch_reg) < 2)
            nom_lvl = max_level_reg;
        else if (int'(s1_ch_reg) < 4)
            nom_lvl = back_nominal_reg;
        else
            nom_lvl = front_nominal_reg;
    end

    always_comb
    begin
        nxt       = cur;
        cnt_new   = cnt_cur;
        fin       = 1'b1;
        cnt_inc   = cnt_cur + 8'd1;
        stepped   = (cnt_inc > cur.speed);
        cnt_step  = stepped ? 8'd0 : cnt_inc;
        rise_sum  = {1'b0, cur.level} + (stepped ? {1'b0, step_size_reg} : 9'd0);
        fall_neg  = stepped && (step_size_reg > cur.level);
        fall_val  = stepped ? (cur.level - step_size_reg) : cur.level;
        floor_lvl = (nom_lvl == max_level_reg) ? min_level_reg : nom_lvl;
        case (cur.prog) inside
            PRG_NOMINAL, PRG_MAX:
            begin
                nxt.level = (cur.prog == PRG_MAX) ? max_level_reg : nom_lvl;
                nxt.speed = '0;
                nxt.phase = PH_START;
                cnt_new   = '0;
            end
            PRG_BRAKE:
                nxt.level = brake_level_reg;
            PRG_FADE:
            begin
                case (cur.phase)
                    PH_START:
                    begin
                        cnt_new   = '0;
                        nxt.phase = PH_ACTIVE;
                        fin       = 1'b0;
                    end
                    PH_ACTIVE:
                    begin
                        if (rise_sum > {1'b0, max_level_reg})
                        begin
                            nxt.level = max_level_reg;
                            nxt.phase = PH_FALL;
                            cnt_new   = '0;
                        end
                        else
                        begin
                            nxt.level = rise_sum[7:0];
                            cnt_new   = cnt_step;
                        end
                    end
                    PH_FALL:
                    begin
                        // a fall below zero always reaches the floor
                        if (fall_neg || (fall_val <= floor_lvl))
                        begin
                            nxt.level = floor_lvl;
                            nxt.phase = PH_ACTIVE;
                            cnt_new   = '0;
                        end
                        else
                        begin
                            nxt.level = fall_val;
                            cnt_new   = cnt_step;
                        end
                    end
                    default:
                    begin
                        nxt.phase = PH_START;
                        fin       = 1'b0;
                    end
                endcase
            end
            PRG_FLASH:
            begin
                case (cur.phase)
                    PH_START:
                    begin
                        cnt_new   = '0;
                        nxt.phase = PH_ACTIVE;
                        fin       = 1'b0;
                    end
                    PH_ACTIVE:
                    begin
                        cnt_new = cnt_step;
                        if (stepped)
                            nxt.level = (cur.level == max_level_reg) ? 8'd0 : max_level_reg;
                    end
                    default:
                    begin
                        nxt.phase = PH_START;
                        fin       = 1'b0;
                    end
                endcase
            end
            default:
            begin
                // off, and unused program codes
                nxt.level = '0;
                nxt.speed = '0;
                nxt.phase = PH_START;
                cnt_new   = '0;
            end
        endcase
    end

    // ---------------- result ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            done_cnt_reg <= '0;
            all_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd_acc && (cmd.operation == OP_LOAD))
            begin
                res_vld_reg  <= 1'b1;
                done_cnt_reg <= '0;
                all_done_reg <= 1'b0;
            end
            else if (state_reg == ST_FINISH)
            begin
                res_vld_reg  <= 1'b1;
                done_cnt_reg <= done_sat;
                all_done_reg <= (done_sat >= done_threshold_reg);
            end
            else if (res.ready)
                res_vld_reg <= 1'b0;
        end
    end

    // level copy of the reported channels, kept alongside the memory
    for (genvar k = 0; k < NUM_SHOWN; k++)
    begin : g_lvl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lvl_reg[k] <= '0;
            else if (s1_vld_reg && (int'(s1_ch_reg) == k))
                lvl_reg[k] <= nxt.level;
            else if (load_hit && (int'(cmd.channel) == k))
                lvl_reg[k] <= cmd.level;
        end
    end

    for (genvar k = 0; k < DUTY_FIELDS; k++)
    begin : g_duty
        if (k < NUM_SHOWN)
        begin : g_on
            logic [PROD_W-1:0] prod;
            assign prod      = PROD_W'(lvl_reg[k]) * PROD_W'(DUTY_SCALE);
            assign duty_w[k] = prod[9:0];
        end
        else
        begin : g_off
            assign duty_w[k] = '0;
        end
    end

    assign res.valid      = res_vld_reg;
    assign res.duty_ch0   = duty_w[0];
    assign res.duty_ch1   = duty_w[1];
    assign res.duty_ch2   = duty_w[2];
    assign res.duty_ch3   = duty_w[3];
    assign res.duty_ch4   = duty_w[4];
    assign res.duty_ch5   = duty_w[5];
    assign res.done_count = done_cnt_reg;
    assign res.all_done   = all_done_reg;

    // ---------------- assertions ----------------
    `LES_ASSERT_NOW(a_no_result_mid_tick, res.valid, state_reg == ST_IDLE,
        "result valid while a tick is in work")
    `LES_ASSERT_NOW(a_writeback_in_tick, s1_vld_reg,
        (state_reg == ST_RUN) || (state_reg == ST_FINISH),
        "channel write-back outside a tick")
    `LES_ASSERT_NOW(a_finish_last_channel, state_reg == ST_FINISH,
        s1_vld_reg && (s1_ch_reg == LAST_CH),
        "tick finished before the last channel was updated")
    `LES_ASSERT_NEXT(a_tick_starts, cmd_acc && (cmd.operation == OP_TICK),
        (state_reg == ST_RUN) && (rd_idx_reg == '0),
        "accepted tick did not start at channel zero")
    `LES_ASSERT_NEXT(a_finish_gives_result, state_reg == ST_FINISH, res.valid,
        "tick finished without a result")

endmodule

// ===== tb/sv/tb_led_effect_sequencer_top.sv =====
// Self-checking testbench of led_effect_sequencer_top: tick and load commands, per-channel
// effect prediction and a field-by-field check of every duty frame under random idling.
// Depends on les_pkg, les_intf.sv and the led_effect_sequencer_top RTL.
module tb_led_effect_sequencer_top;
    import les_pkg::*;

    localparam int NUM_LEDS   = 6;
    localparam int DUTY_MULT  = 4;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 20;

    // Codes the package leaves unnamed
    localparam phase_t PH_UNUSED = 2'd3;
    localparam prog_t  PRG_RSVD6 = 3'd6;
    localparam prog_t  PRG_RSVD7 = 3'd7;

    typedef struct {
        logic   op;
        chan_t  ch;
        prog_t  prg;
        level_t lvl;
        phase_t ph;
        level_t spd;
    } led_cmd_t;

    typedef struct {
        duty_t  duty [DUTY_FIELDS];
        count_t done;
        logic   all;
    } duty_frame_t;

    logic clk;
    logic rst_n;

    les_in_if  cmd_if ();
    les_out_if res_if ();
    les_cfg_if cfg_if ();

    led_effect_sequencer_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    led_cmd_t    led_cmd_q [$];
    duty_frame_t duty_expect_q [$];
    int          err_count = 0;
    int          src_idle_pct;
    int          snk_stall_pct;
    logic        hold_arm;
    int          hold_left = 0;

    // Mirror of the block's registers and channel state
    level_t cfg_max, cfg_min, cfg_brake, cfg_back, cfg_front, cfg_step;
    count_t cfg_thr;
    prog_t  led_prog  [NUM_LEDS];
    level_t led_level [NUM_LEDS];
    level_t led_speed [NUM_LEDS];
    phase_t led_phase [NUM_LEDS];
    level_t led_cnt   [NUM_LEDS];

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic level_t nominal_level(int c);
        if (c < 2)
            return cfg_max;
        if (c < 4)
            return cfg_back;
        return cfg_front;
    endfunction

    function automatic void clear_channel(int c, level_t lvl);
        led_level[c] = lvl;
        led_speed[c] = '0;
        led_phase[c] = PH_START;
        led_cnt[c]   = '0;
    endfunction

    // Advance the rate divider; true when a step is due
    function automatic bit rate_step(int c);
        led_cnt[c] = led_cnt[c] + 8'd1;
        if (led_cnt[c] > led_speed[c])
        begin
            led_cnt[c] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Run one channel's program for a tick; true when the channel reports finished
    function automatic bit run_effect(int c);
        level_t nom;
        int     v;
        nom = nominal_level(c);
        case (led_prog[c])
            PRG_NOMINAL:
            begin
                clear_channel(c, nom);
                return 1'b1;
            end
            PRG_MAX:
            begin
                clear_channel(c, cfg_max);
                return 1'b1;
            end
            PRG_BRAKE:
            begin
                led_level[c] = cfg_brake;
                return 1'b1;
            end
            PRG_FADE:
            begin
                if (led_phase[c] == PH_START)
                begin
                    led_cnt[c]   = '0;
                    led_phase[c] = PH_ACTIVE;
                    return 1'b0;
                end
                if (led_phase[c] == PH_ACTIVE)
                begin
                    v = int'(led_level[c]);
                    if (rate_step(c))
                        v += int'(cfg_step);
                    if (v > int'(cfg_max))
                    begin
                        led_level[c] = cfg_max;
                        led_phase[c] = PH_FALL;
                        led_cnt[c]   = '0;
                    end
                    else
                        led_level[c] = level_t'(v);
                    return 1'b1;
                end
                if (led_phase[c] == PH_FALL)
                begin
                    v = int'(led_level[c]);
                    if (rate_step(c))
                        v -= int'(cfg_step);
                    // floor is the nominal, or min_level when the nominal is full scale
                    if (nom != cfg_max && v <= int'(nom))
                    begin
                        led_level[c] = nom;
                        led_phase[c] = PH_ACTIVE;
                        led_cnt[c]   = '0;
                    end
                    else if (nom == cfg_max && v <= int'(cfg_min))
                    begin
                        led_level[c] = cfg_min;
                        led_phase[c] = PH_ACTIVE;
                        led_cnt[c]   = '0;
                    end
                    else
                        led_level[c] = (v < 0) ? level_t'(0) : level_t'(v);
                    return 1'b1;
                end
                led_phase[c] = PH_START;
                return 1'b0;
            end
            PRG_FLASH:
            begin
                if (led_phase[c] == PH_START)
                begin
                    led_cnt[c]   = '0;
                    led_phase[c] = PH_ACTIVE;
                    return 1'b0;
                end
                if (led_phase[c] == PH_ACTIVE)
                begin
                    if (rate_step(c))
                        led_level[c] = (led_level[c] == cfg_max) ? level_t'(0) : cfg_max;
                    return 1'b1;
                end
                led_phase[c] = PH_START;
                return 1'b0;
            end
            default:
            begin
                clear_channel(c, '0);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic duty_frame_t predict_duties(led_cmd_t it);
        duty_frame_t f;
        int          done;
        done = 0;
        if (it.op == OP_LOAD)
        begin
            if (it.ch < NUM_LEDS)
            begin
                led_prog[it.ch]  = it.prg;
                led_level[it.ch] = it.lvl;
                led_phase[it.ch] = it.ph;
                led_speed[it.ch] = it.spd;
            end
            f.all = 1'b0;
        end
        else
        begin
            for (int c = 0; c < NUM_LEDS; c++)
                done += run_effect(c);
            if (done > 7)
                done = 7;
            f.all = (done >= int'(cfg_thr));
        end
        f.done = count_t'(done);
        for (int k = 0; k < DUTY_FIELDS; k++)
            f.duty[k] = (k < NUM_LEDS) ? duty_t'(led_level[k] * DUTY_MULT) : '0;
        return f;
    endfunction

    function automatic void queue_load(chan_t ch, prog_t p, level_t l, phase_t ph, level_t s);
        led_cmd_t it;
        it = '{op: OP_LOAD, ch: ch, prg: p, lvl: l, ph: ph, spd: s};
        led_cmd_q.push_back(it);
    endfunction

    function automatic led_cmd_t random_cmd();
        led_cmd_t it;
        it.op  = ($urandom_range(99) < 55) ? OP_TICK : OP_LOAD;
        it.ch  = ($urandom_range(99) < 90) ? chan_t'($urandom_range(5))
                                            : chan_t'($urandom_range(7, 6));
        it.lvl = level_t'($urandom_range(255));
        it.ph  = ($urandom_range(99) < 70) ? PH_START : phase_t'($urandom_range(3));
        it.spd = ($urandom_range(99) < 70) ? level_t'($urandom_range(3))
                                            : level_t'($urandom_range(255));
        // favor the stateful effects, keep every program code reachable
        case ($urandom_range(9)) inside
            [0:3]:   it.prg = PRG_FADE;
            [4:6]:   it.prg = PRG_FLASH;
            default: it.prg = prog_t'($urandom_range(7));
        endcase
        return it;
    endfunction

    function automatic void queue_ticks(int n);
        led_cmd_t it;
        for (int i = 0; i < n; i++)
        begin
            it = random_cmd();
            it.op = OP_TICK;
            led_cmd_q.push_back(it);
        end
    endfunction

    // Command driver: predict on acceptance, then offer the next pending command
    always @(posedge clk)
    begin
        led_cmd_t acc;
        led_cmd_t nxt;
        if (!rst_n)
        begin
            cmd_if.valid       <= 1'b0;
            cmd_if.operation   <= OP_TICK;
            cmd_if.channel     <= '0;
            cmd_if.program_req <= PRG_OFF;
            cmd_if.level       <= '0;
            cmd_if.phase       <= PH_START;
            cmd_if.speed       <= '0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                acc = '{op: cmd_if.operation, ch: cmd_if.channel, prg: cmd_if.program_req,
                        lvl: cmd_if.level, ph: cmd_if.phase, spd: cmd_if.speed};
                duty_expect_q.push_back(predict_duties(acc));
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (led_cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = led_cmd_q.pop_front();
                    cmd_if.valid       <= 1'b1;
                    cmd_if.operation   <= nxt.op;
                    cmd_if.channel     <= nxt.ch;
                    cmd_if.program_req <= nxt.prg;
                    cmd_if.level       <= nxt.lvl;
                    cmd_if.phase       <= nxt.ph;
                    cmd_if.speed       <= nxt.spd;
                end
                else
                    cmd_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_arm)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_frame();
        duty_frame_t want;
        duty_t       seen [DUTY_FIELDS];
        seen = '{res_if.duty_ch0, res_if.duty_ch1, res_if.duty_ch2,
                 res_if.duty_ch3, res_if.duty_ch4, res_if.duty_ch5};
        if (duty_expect_q.size() == 0)
        begin
            flag_error("result transaction with nothing expected");
            return;
        end
        want = duty_expect_q.pop_front();
        for (int k = 0; k < DUTY_FIELDS; k++)
            if (seen[k] !== want.duty[k])
                flag_error($sformatf("duty_ch%0d: got %0d, expected %0d",
                                     k, seen[k], want.duty[k]));
        if (res_if.done_count !== want.done)
            flag_error($sformatf("done_count: got %0d, expected %0d",
                                 res_if.done_count, want.done));
        if (res_if.all_done !== want.all)
            flag_error($sformatf("all_done: got %0b, expected %0b",
                                 res_if.all_done, want.all));
    endtask

    // Result monitor and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            check_frame();
        res_if.ready <= (hold_arm || hold_left != 0) ? 1'b0
                                                    : ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic write_reg(cfg_addr_t a, level_t d);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= a;
        cfg_if.data  <= d;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (a)
            CFG_MAX_LEVEL:      cfg_max   = d;
            CFG_MIN_LEVEL:      cfg_min   = d;
            CFG_BRAKE_LEVEL:    cfg_brake = d;
            CFG_BACK_NOMINAL:   cfg_back  = d;
            CFG_FRONT_NOMINAL:  cfg_front = d;
            CFG_STEP_SIZE:      cfg_step  = d;
            CFG_DONE_THRESHOLD: cfg_thr   = count_t'(d);
            default: ;
        endcase
    endtask

    task automatic set_config(level_t mx, level_t mn, level_t br, level_t bk, level_t fr,
                              level_t st, level_t th);
        write_reg(CFG_MAX_LEVEL, mx);
        write_reg(CFG_MIN_LEVEL, mn);
        write_reg(CFG_BRAKE_LEVEL, br);
        write_reg(CFG_BACK_NOMINAL, bk);
        write_reg(CFG_FRONT_NOMINAL, fr);
        write_reg(CFG_STEP_SIZE, st);
        write_reg(CFG_DONE_THRESHOLD, th);
    endtask

    task automatic random_config();
        level_t mx;
        mx = ($urandom_range(3) == 0) ? level_t'($urandom_range(255))
                                      : level_t'($urandom_range(255, 120));
        set_config(mx, level_t'($urandom_range(255)), level_t'($urandom_range(255)),
                   ($urandom_range(4) == 0) ? mx : level_t'($urandom_range(255)),
                   ($urandom_range(4) == 0) ? mx : level_t'($urandom_range(255)),
                   ($urandom_range(99) < 70) ? level_t'($urandom_range(8, 1))
                                             : level_t'($urandom_range(255, 1)),
                   level_t'($urandom_range(6)));
    endtask

    // Hold until every command is in and every frame is out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (led_cmd_q.size() != 0 || cmd_if.valid || duty_expect_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(int n, int src_pct, int snk_pct);
        src_idle_pct  <= src_pct;
        snk_stall_pct <= snk_pct;
        for (int i = 0; i < n; i++)
            led_cmd_q.push_back(random_cmd());
        wait_drained();
    endtask

    initial
    begin
        cfg_if.valid       <= 1'b0;
        cfg_if.addr        <= CFG_MAX_LEVEL;
        cfg_if.data        <= '0;
        hold_arm           <= 1'b0;
        src_idle_pct       <= 0;
        snk_stall_pct      <= 0;
        rst_n = 1'b0;

        cfg_max   = 8'd255;
        cfg_min   = 8'd0;
        cfg_brake = 8'd200;
        cfg_back  = 8'd64;
        cfg_front = 8'd128;
        cfg_step  = 8'd1;
        cfg_thr   = 3'd5;
        for (int c = 0; c < NUM_LEDS; c++)
        begin
            led_prog[c] = PRG_OFF;
            clear_channel(c, '0);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every program, field extremes, ignored channels, reserved programs
        queue_load(3'd0, PRG_FADE, 8'd0, PH_START, 8'd0);
        queue_load(3'd1, PRG_FLASH, 8'd255, PH_START, 8'd0);
        queue_load(3'd2, PRG_NOMINAL, 8'd17, PH_UNUSED, 8'd255);
        queue_load(3'd3, PRG_BRAKE, 8'd255, PH_FALL, 8'd1);
        queue_load(3'd4, PRG_MAX, 8'd0, PH_ACTIVE, 8'd0);
        queue_load(3'd5, PRG_OFF, 8'd200, PH_START, 8'd9);
        queue_load(3'd6, PRG_FADE, 8'd77, PH_ACTIVE, 8'd0);
        queue_load(3'd7, PRG_FLASH, 8'd255, PH_UNUSED, 8'd255);
        queue_ticks(4);
        queue_load(3'd5, PRG_RSVD6, 8'd99, PH_ACTIVE, 8'd2);
        queue_load(3'd4, PRG_RSVD7, 8'd1, PH_UNUSED, 8'd255);
        queue_load(3'd2, PRG_FADE, 8'd255, PH_FALL, 8'd0);
        queue_load(3'd3, PRG_FADE, 8'd3, PH_UNUSED, 8'd255);
        queue_load(3'd0, PRG_FLASH, 8'd10, PH_FALL, 8'd0);
        queue_ticks(5);
        wait_drained();

        run_random(200, 0, 0);
        set_config(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
        run_random(200, 61, 0);
        set_config(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd1, 8'd6);
        run_random(200, 0, 61);
        random_config();
        run_random(200, 31, 31);

        // Stall the receiver while commands keep coming so the input backs up
        random_config();
        src_idle_pct  <= 0;
        snk_stall_pct <= 0;
        for (int i = 0; i < 60; i++)
            led_cmd_q.push_back(random_cmd());
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
        wait_drained();

        random_config();
        run_random(150, 31, 31);
        random_config();
        run_random(150, 0, 0);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
